// ===== hw/rtl/fss_pkg.sv =====
// fss_pkg: shared types, constants and helper functions for the fingerprint similarity block
// depends on nothing; imported by every module of the block

package fss_pkg;

    // fixed-point constants
    localparam logic [16:0] ONE_Q16       = 17'h10000;
    localparam logic [19:0] TWO_TURNS     = 20'd184320;
    localparam logic [19:0] FULL_TURN     = 20'd92160;
    localparam logic [16:0] QUARTER       = 17'd23040;
    localparam logic [14:0] RECIP_45      = 15'd23301;   // floor(2^20 / 45)
    localparam logic [24:0] EIGHT_OVER_PI = 25'd166886;  // 8/pi in Q16

    // accumulator limits
    localparam logic signed [23:0] SUM_S_MAX = 24'sd4194303;
    localparam logic signed [23:0] SUM_S_MIN = -24'sd4194304;
    localparam logic [21:0]        SUM_W_MAX = 22'd4194303;
    localparam logic [22:0]        SUM_T_MAX = 23'd8388607;

    // register reset values
    localparam logic [15:0] RST_WEIGHT_ORIENT     = 16'd10486;
    localparam logic [15:0] RST_WEIGHT_FREQ       = 16'd24248;
    localparam logic [15:0] RST_WEIGHT_AVG_FREQ   = 16'd10486;
    localparam logic [15:0] RST_WEIGHT_AVG_ORIENT = 16'd20316;

    // register indexes
    localparam logic [7:0] REG_WEIGHT_ORIENT     = 8'd0;
    localparam logic [7:0] REG_WEIGHT_FREQ       = 8'd1;
    localparam logic [7:0] REG_WEIGHT_AVG_FREQ   = 8'd2;
    localparam logic [7:0] REG_WEIGHT_AVG_ORIENT = 8'd3;

    // queue and divider sizing
    localparam int unsigned Q_DEPTH_DEFAULT = 2;
    localparam int unsigned DIV_NUM_W       = 40;
    localparam int unsigned DIV_DEN_W       = 23;

    // fault bit positions
    localparam int unsigned FAULT_WEIGHT = 0;
    localparam int unsigned FAULT_TOTAL  = 1;
    localparam int unsigned FAULT_AVG    = 2;

    typedef enum logic [3:0] {
        F_IDLE,
        F_PREP,
        F_UFIX,
        F_SQ,
        F_HORN,
        F_HFIN,
        F_WCOS,
        F_WSIN,
        F_ACC,
        F_PUSH
    } t_front_state;

    typedef enum logic [3:0] {
        B_IDLE,
        B_SQC,
        B_SQS,
        B_ROOT,
        B_DIV1,
        B_DIV2,
        B_DIV3,
        B_S4,
        B_MUL,
        B_FIN,
        B_OUT
    } t_back_state;

    // one finished comparison handed from the front to the back
    typedef struct packed {
        logic signed [22:0] sum_cos;
        logic signed [22:0] sum_sin;
        logic [21:0]        sum_weight;
        logic [21:0]        sum_absdiff;
        logic [22:0]        sum_total;
        logic [15:0]        query_avg_freq;
        logic [15:0]        cand_avg_freq;
        logic signed [15:0] query_avg_orient;
        logic signed [15:0] cand_avg_orient;
        logic [15:0]        cand_ident;
    } t_cell_sums;

    typedef struct packed {
        logic [15:0] orient;
        logic [15:0] freq;
        logic [15:0] avg_freq;
        logic [15:0] avg_orient;
    } t_weights;

    // coefficients of the quarter-sine polynomial, innermost first
    function automatic logic [16:0] horner_coef(input logic [1:0] step);
        logic [16:0] c;
        unique case (step)
            2'd0: c = 17'd307;
            2'd1: c = 17'd5223;
            2'd2: c = 17'd42334;
            2'd3: c = 17'd102944;
            default: c = 17'd0;
        endcase
        return c;
    endfunction

endpackage

// ===== hw/rtl/fingerprint_similarity_score.sv =====
// Fingerprint similarity score. For each cell pair that it takes, and before it takes the next, the front sequencer
// runs the coherence weight, the quarter-sine polynomial for sine and cosine and the two
// weighted terms through one shared 17x17 multiplier, then updates the saturating sums. A
// cell marked last then closes the comparison and hands its sums to a QUEUE_DEPTH-entry
// queue, and waits there while the queue is full; the back end then runs 31 square-root
// steps and three divisions on the shared divider, each of 40 quotient steps with a start
// and a finish, then the weighted total, before the result is taken, while the front keeps
// accepting cells of the next comparison.
// Weight registers are written through the configuration channel, which is always ready.

module fingerprint_similarity_score
    import fss_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = Q_DEPTH_DEFAULT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [15:0]        i_query_orient,
    input  logic [15:0]        i_query_coher,
    input  logic [15:0]        i_query_freq,
    input  logic [15:0]        i_cand_orient,
    input  logic [15:0]        i_cand_coher,
    input  logic [15:0]        i_cand_freq,
    input  logic [15:0]        i_query_avg_freq,
    input  logic [15:0]        i_cand_avg_freq,
    input  logic signed [15:0] i_query_avg_orient,
    input  logic signed [15:0] i_cand_avg_orient,
    input  logic [15:0]        i_cand_ident,
    input  logic               i_last_cell,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [16:0]        o_orient_sim,
    output logic [16:0]        o_freq_sim,
    output logic [16:0]        o_avg_freq_sim,
    output logic signed [17:0] o_avg_orient_sim,
    output logic signed [17:0] o_total_score,
    output logic [15:0]        o_result_ident,
    output logic [2:0]         o_div_fault,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [7:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);

    t_weights   r_weights;
    t_cell_sums q_in, q_head;
    logic       q_push, q_full, q_pop, q_empty;

    assign o_cfg_ready = 1'b1;

    // weight registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weights.orient     <= RST_WEIGHT_ORIENT;
            r_weights.freq       <= RST_WEIGHT_FREQ;
            r_weights.avg_freq   <= RST_WEIGHT_AVG_FREQ;
            r_weights.avg_orient <= RST_WEIGHT_AVG_ORIENT;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_WEIGHT_ORIENT:     r_weights.orient     <= i_cfg_data;
                REG_WEIGHT_FREQ:       r_weights.freq       <= i_cfg_data;
                REG_WEIGHT_AVG_FREQ:   r_weights.avg_freq   <= i_cfg_data;
                REG_WEIGHT_AVG_ORIENT: r_weights.avg_orient <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    fss_front u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_query_orient     (i_query_orient),
        .i_query_coher      (i_query_coher),
        .i_query_freq       (i_query_freq),
        .i_cand_orient      (i_cand_orient),
        .i_cand_coher       (i_cand_coher),
        .i_cand_freq        (i_cand_freq),
        .i_query_avg_freq   (i_query_avg_freq),
        .i_cand_avg_freq    (i_cand_avg_freq),
        .i_query_avg_orient (i_query_avg_orient),
        .i_cand_avg_orient  (i_cand_avg_orient),
        .i_cand_ident       (i_cand_ident),
        .i_last_cell        (i_last_cell),
        .i_q_full           (q_full),
        .o_push             (q_push),
        .o_entry            (q_in)
    );

    fss_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_empty (q_empty)
    );

    fss_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_empty        (q_empty),
        .i_head           (q_head),
        .o_pop            (q_pop),
        .i_weights        (r_weights),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_orient_sim     (o_orient_sim),
        .o_freq_sim       (o_freq_sim),
        .o_avg_freq_sim   (o_avg_freq_sim),
        .o_avg_orient_sim (o_avg_orient_sim),
        .o_total_score    (o_total_score),
        .o_result_ident   (o_result_ident),
        .o_div_fault      (o_div_fault)
    );

endmodule

// ===== hw/rtl/fss_front.sv =====
// fss_front: per-cell sequencer, coherence weight, quarter-sine and saturating accumulators
// depends on fss_pkg; feeds finished sums into fss_queue

module fss_front
    import fss_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [15:0]        i_query_orient,
    input  logic [15:0]        i_query_coher,
    input  logic [15:0]        i_query_freq,
    input  logic [15:0]        i_cand_orient,
    input  logic [15:0]        i_cand_coher,
    input  logic [15:0]        i_cand_freq,
    input  logic [15:0]        i_query_avg_freq,
    input  logic [15:0]        i_cand_avg_freq,
    input  logic signed [15:0] i_query_avg_orient,
    input  logic signed [15:0] i_cand_avg_orient,
    input  logic [15:0]        i_cand_ident,
    input  logic               i_last_cell,
    input  logic               i_q_full,
    output logic               o_push,
    output t_cell_sums         o_entry
);

    t_front_state r_state, n_state;

    // captured cell
    logic [15:0]        r_qo, r_qc, r_qf, r_co, r_cc, r_cf;
    logic [15:0]        r_qa, r_ca, r_ident;
    logic signed [15:0] r_qao, r_cao;
    logic               r_last;

    // working registers
    logic [15:0]        r_w, n_w;
    logic [1:0]         r_quad, n_quad;
    logic [21:0]        r_x, n_x;
    logic [15:0]        r_q0, n_q0;
    logic [15:0]        r_u, n_u;
    logic [16:0]        r_u2, n_u2;
    logic [16:0]        r_p, n_p;
    logic [1:0]         r_hcnt, n_hcnt;
    logic               r_second, n_second;
    logic [16:0]        r_su, n_su, r_sc, n_sc;
    logic signed [16:0] r_tcos, n_tcos, r_tsin, n_tsin;

    // accumulators
    logic signed [22:0] r_sum_cos, n_sum_cos, r_sum_sin, n_sum_sin;
    logic [21:0]        r_sum_weight, n_sum_weight, r_sum_absdiff, n_sum_absdiff;
    logic [22:0]        r_sum_total, n_sum_total;

    // shared 17x17 multiplier
    logic [16:0] mul_a, mul_b;
    logic [33:0] mul_p;

    // angle reduction
    logic [19:0] d_raw;
    logic [16:0] d_red;
    logic [1:0]  quad;
    logic [16:0] rem;
    logic [36:0] recip_p;
    logic [21:0] q0_x45;
    logic [21:0] u_err;
    logic [16:0] arg;
    logic [17:0] hv;
    logic [16:0] hval;
    logic [16:0] mag;
    logic        neg;
    logic [15:0] wt;

    // accumulation sums
    logic signed [23:0] cos_sum, sin_sum;
    logic [22:0]        w_sum, ad_sum;
    logic [15:0]        fdiff;
    logic [23:0]        t_sum;

    assign mul_p = mul_a * mul_b;

    // twice the orientation difference, reduced into one turn and split into quadrants
    assign d_raw = {3'b000, r_qo, 1'b0} + TWO_TURNS - {3'b000, r_co, 1'b0};

    always_comb begin
        priority if (d_raw >= 20'd276480) begin
            d_red = 17'(d_raw - 20'd276480);
        end else if (d_raw >= TWO_TURNS) begin
            d_red = 17'(d_raw - TWO_TURNS);
        end else if (d_raw >= FULL_TURN) begin
            d_red = 17'(d_raw - FULL_TURN);
        end else begin
            d_red = d_raw[16:0];
        end
        priority if (d_red >= 17'd69120) begin
            quad = 2'd3;
            rem  = d_red - 17'd69120;
        end else if (d_red >= 17'd46080) begin
            quad = 2'd2;
            rem  = d_red - 17'd46080;
        end else if (d_red >= QUARTER) begin
            quad = 2'd1;
            rem  = d_red - QUARTER;
        end else begin
            quad = 2'd0;
            rem  = d_red;
        end
    end

    // u = rem * 128 / 45 by reciprocal, corrected in the next cycle
    assign recip_p = {rem[14:0], 7'b0} * RECIP_45;
    assign q0_x45  = {6'b0, r_q0} * 22'd45;
    assign u_err   = r_x - q0_x45;

    // polynomial argument: u for the sine, one minus u for the cosine
    assign arg = r_second ? (ONE_Q16 - {1'b0, r_u}) : {1'b0, r_u};

    assign hv    = mul_p[33:16];
    assign hval  = (hv > {1'b0, ONE_Q16}) ? ONE_Q16 : hv[16:0];
    assign wt    = mul_p[31:16];
    assign fdiff = (r_qf > r_cf) ? (r_qf - r_cf) : (r_cf - r_qf);

    assign cos_sum = {r_sum_cos[22], r_sum_cos} + {{7{r_tcos[16]}}, r_tcos};
    assign sin_sum = {r_sum_sin[22], r_sum_sin} + {{7{r_tsin[16]}}, r_tsin};
    assign w_sum   = {1'b0, r_sum_weight} + {7'b0, r_w};
    assign ad_sum  = {1'b0, r_sum_absdiff} + {7'b0, fdiff};
    assign t_sum   = {1'b0, r_sum_total} + {7'b0, ({1'b0, r_qf} + {1'b0, r_cf})};

    assign o_stall = (r_state != F_IDLE);

    // queue entry built from the closed sums
    always_comb begin
        o_entry.sum_cos          = r_sum_cos;
        o_entry.sum_sin          = r_sum_sin;
        o_entry.sum_weight       = r_sum_weight;
        o_entry.sum_absdiff      = r_sum_absdiff;
        o_entry.sum_total        = r_sum_total;
        o_entry.query_avg_freq   = r_qa;
        o_entry.cand_avg_freq    = r_ca;
        o_entry.query_avg_orient = r_qao;
        o_entry.cand_avg_orient  = r_cao;
        o_entry.cand_ident       = r_ident;
    end

    // next state and datapath
    always_comb begin
        n_state       = r_state;
        n_w           = r_w;
        n_quad        = r_quad;
        n_x           = r_x;
        n_q0          = r_q0;
        n_u           = r_u;
        n_u2          = r_u2;
        n_p           = r_p;
        n_hcnt        = r_hcnt;
        n_second      = r_second;
        n_su          = r_su;
        n_sc          = r_sc;
        n_tcos        = r_tcos;
        n_tsin        = r_tsin;
        n_sum_cos     = r_sum_cos;
        n_sum_sin     = r_sum_sin;
        n_sum_weight  = r_sum_weight;
        n_sum_absdiff = r_sum_absdiff;
        n_sum_total   = r_sum_total;
        mul_a         = '0;
        mul_b         = '0;
        mag           = '0;
        neg           = 1'b0;
        o_push        = 1'b0;
        unique case (r_state)
            F_IDLE: begin
                if (i_valid) begin
                    n_state = F_PREP;
                end
            end
            F_PREP: begin
                mul_a   = {1'b0, r_qc};
                mul_b   = {1'b0, r_cc};
                n_w     = mul_p[31:16];
                n_quad  = quad;
                n_x     = {rem[14:0], 7'b0};
                n_q0    = recip_p[35:20];
                n_state = F_UFIX;
            end
            F_UFIX: begin
                priority if (u_err >= 22'd90) begin
                    n_u = r_q0 + 16'd2;
                end else if (u_err >= 22'd45) begin
                    n_u = r_q0 + 16'd1;
                end else begin
                    n_u = r_q0;
                end
                n_second = 1'b0;
                n_state  = F_SQ;
            end
            F_SQ: begin
                mul_a   = arg;
                mul_b   = arg;
                n_u2    = mul_p[32:16];
                n_p     = 17'd11;
                n_hcnt  = 2'd0;
                n_state = F_HORN;
            end
            F_HORN: begin
                mul_a  = r_p;
                mul_b  = r_u2;
                n_p    = horner_coef(r_hcnt) - mul_p[32:16];
                n_hcnt = r_hcnt + 2'd1;
                if (r_hcnt == 2'd3) begin
                    n_state = F_HFIN;
                end
            end
            F_HFIN: begin
                mul_a = r_p;
                mul_b = arg;
                if (!r_second) begin
                    n_su     = hval;
                    n_second = 1'b1;
                    n_state  = F_SQ;
                end else begin
                    n_sc    = hval;
                    n_state = F_WCOS;
                end
            end
            F_WCOS: begin
                mag    = r_quad[0] ? r_su : r_sc;
                neg    = r_quad[0] ^ r_quad[1];
                mul_a  = {1'b0, r_w};
                mul_b  = mag;
                n_tcos = neg ? -$signed({1'b0, wt}) : $signed({1'b0, wt});
                n_state = F_WSIN;
            end
            F_WSIN: begin
                mag    = r_quad[0] ? r_sc : r_su;
                neg    = r_quad[1];
                mul_a  = {1'b0, r_w};
                mul_b  = mag;
                n_tsin = neg ? -$signed({1'b0, wt}) : $signed({1'b0, wt});
                n_state = F_ACC;
            end
            F_ACC: begin
                priority if (cos_sum > SUM_S_MAX) begin
                    n_sum_cos = SUM_S_MAX[22:0];
                end else if (cos_sum < SUM_S_MIN) begin
                    n_sum_cos = SUM_S_MIN[22:0];
                end else begin
                    n_sum_cos = cos_sum[22:0];
                end
                priority if (sin_sum > SUM_S_MAX) begin
                    n_sum_sin = SUM_S_MAX[22:0];
                end else if (sin_sum < SUM_S_MIN) begin
                    n_sum_sin = SUM_S_MIN[22:0];
                end else begin
                    n_sum_sin = sin_sum[22:0];
                end
                n_sum_weight  = (w_sum > {1'b0, SUM_W_MAX}) ? SUM_W_MAX : w_sum[21:0];
                n_sum_absdiff = (ad_sum > {1'b0, SUM_W_MAX}) ? SUM_W_MAX : ad_sum[21:0];
                n_sum_total   = (t_sum > {1'b0, SUM_T_MAX}) ? SUM_T_MAX : t_sum[22:0];
                n_state       = r_last ? F_PUSH : F_IDLE;
            end
            F_PUSH: begin
                if (!i_q_full) begin
                    o_push        = 1'b1;
                    n_sum_cos     = '0;
                    n_sum_sin     = '0;
                    n_sum_weight  = '0;
                    n_sum_absdiff = '0;
                    n_sum_total   = '0;
                    n_state       = F_IDLE;
                end
            end
            default: begin
                n_state = F_IDLE;
            end
        endcase
    end

    // state and accumulators
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= F_IDLE;
            r_sum_cos     <= '0;
            r_sum_sin     <= '0;
            r_sum_weight  <= '0;
            r_sum_absdiff <= '0;
            r_sum_total   <= '0;
        end else begin
            r_state       <= n_state;
            r_sum_cos     <= n_sum_cos;
            r_sum_sin     <= n_sum_sin;
            r_sum_weight  <= n_sum_weight;
            r_sum_absdiff <= n_sum_absdiff;
            r_sum_total   <= n_sum_total;
        end
    end

    // cell capture and working registers
    always_ff @(posedge i_clk) begin
        if (r_state == F_IDLE && i_valid) begin
            r_qo    <= i_query_orient;
            r_qc    <= i_query_coher;
            r_qf    <= i_query_freq;
            r_co    <= i_cand_orient;
            r_cc    <= i_cand_coher;
            r_cf    <= i_cand_freq;
            r_qa    <= i_query_avg_freq;
            r_ca    <= i_cand_avg_freq;
            r_qao   <= i_query_avg_orient;
            r_cao   <= i_cand_avg_orient;
            r_ident <= i_cand_ident;
            r_last  <= i_last_cell;
        end
        r_w      <= n_w;
        r_quad   <= n_quad;
        r_x      <= n_x;
        r_q0     <= n_q0;
        r_u      <= n_u;
        r_u2     <= n_u2;
        r_p      <= n_p;
        r_hcnt   <= n_hcnt;
        r_second <= n_second;
        r_su     <= n_su;
        r_sc     <= n_sc;
        r_tcos   <= n_tcos;
        r_tsin   <= n_tsin;
    end

endmodule

// ===== hw/rtl/fss_queue.sv =====
// fss_queue: short queue of finished comparisons between front and back
// depends on fss_pkg for the entry type

module fss_queue
    import fss_pkg::*;
#(
    parameter int unsigned DEPTH = Q_DEPTH_DEFAULT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_cell_sums i_entry,
    output logic       o_full,
    input  logic       i_pop,
    output t_cell_sums o_head,
    output logic       o_empty
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_cell_sums       r_mem [DEPTH];
    logic [AW-1:0]    r_wr, r_rd;
    logic [CW-1:0]    r_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

endmodule

// ===== hw/rtl/fss_div.sv =====
// fss_div: restoring divider, one quotient bit per cycle
// depends on fss_pkg for operand widths

module fss_div
    import fss_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [DIV_NUM_W-1:0] i_num,
    input  logic [DIV_DEN_W-1:0] i_den,
    output logic                 o_done,
    output logic [DIV_NUM_W-1:0] o_quot
);

    localparam int unsigned CNTW = $clog2(DIV_NUM_W + 1);

    logic                 r_busy, r_done;
    logic [CNTW-1:0]      r_cnt;
    logic [DIV_NUM_W-1:0] r_num;
    logic [DIV_DEN_W-1:0] r_rem, r_den;
    logic [DIV_DEN_W:0]   rem_sh, rem_sub;
    logic                 qbit;

    // one trial subtraction
    assign rem_sh  = {r_rem, r_num[DIV_NUM_W-1]};
    assign qbit    = (rem_sh >= {1'b0, r_den});
    assign rem_sub = rem_sh - {1'b0, r_den};

    assign o_done = r_done;
    assign o_quot = r_num;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNTW'(DIV_NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNTW'(1);
                if (r_cnt == CNTW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // quotient shifts into the dividend register
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[DIV_NUM_W-2:0], qbit};
            r_rem <= qbit ? rem_sub[DIV_DEN_W-1:0] : rem_sh[DIV_DEN_W-1:0];
        end
    end

endmodule

// ===== hw/rtl/fss_back.sv =====
// fss_back: final similarities, square root, shared divider and weighted total
// depends on fss_pkg and fss_div; takes entries from fss_queue

module fss_back
    import fss_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_empty,
    input  t_cell_sums         i_head,
    output logic               o_pop,
    input  t_weights           i_weights,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [16:0]        o_orient_sim,
    output logic [16:0]        o_freq_sim,
    output logic [16:0]        o_avg_freq_sim,
    output logic signed [17:0] o_avg_orient_sim,
    output logic signed [17:0] o_total_score,
    output logic [15:0]        o_result_ident,
    output logic [2:0]         o_div_fault
);

    t_back_state r_state, n_state;

    t_cell_sums         r_e, n_e;
    logic [45:0]        r_sq, n_sq;
    logic [61:0]        r_root_v, n_root_v, r_root_r, n_root_r;
    logic [4:0]         r_k, n_k;
    logic               r_div_run, n_div_run;
    logic [16:0]        r_s1, n_s1, r_s2, n_s2, r_s3, n_s3;
    logic signed [17:0] r_s4, n_s4;
    logic [2:0]         r_fault, n_fault;
    logic [1:0]         r_mcnt, n_mcnt;
    logic signed [35:0] r_acc, n_acc;

    logic               r_out_valid, n_out_valid;
    logic [16:0]        r_o_s1, r_o_s2, r_o_s3;
    logic signed [17:0] r_o_s4, r_o_tot;
    logic [15:0]        r_o_ident;
    logic [2:0]         r_o_fault;
    logic               load_out;

    // shared signed multiplier
    logic signed [24:0] bm_a, bm_b;
    logic signed [49:0] bm_p;

    // divider port
    logic                 div_start, div_done;
    logic [DIV_NUM_W-1:0] div_num, div_quot;
    logic [DIV_DEN_W-1:0] div_den;

    // helpers
    logic [45:0]        sq_tot;
    logic [61:0]        root_b, root_t;
    logic [15:0]        avg_mx, avg_ad;
    logic signed [16:0] ao_diff;
    logic [16:0]        ao_abs;
    logic [17:0]        ao_t;
    logic signed [18:0] s4_w;
    logic [15:0]        wsel;
    logic signed [17:0] ssel;
    logic signed [19:0] tot_w;

    assign bm_p = bm_a * bm_b;

    fss_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    assign sq_tot  = r_sq + bm_p[45:0];
    assign root_b  = 62'(1) << {r_k, 1'b0};
    assign root_t  = r_root_r + root_b;
    assign avg_mx  = (r_e.query_avg_freq > r_e.cand_avg_freq) ? r_e.query_avg_freq
                                                                : r_e.cand_avg_freq;
    assign avg_ad  = (r_e.query_avg_freq > r_e.cand_avg_freq)
                   ? (r_e.query_avg_freq - r_e.cand_avg_freq)
                   : (r_e.cand_avg_freq - r_e.query_avg_freq);
    assign ao_diff = 17'(r_e.query_avg_orient) - 17'(r_e.cand_avg_orient);
    assign ao_abs  = ao_diff[16] ? 17'(-ao_diff) : 17'(ao_diff);
    assign ao_t    = bm_p[33:16];
    assign s4_w    = 19'sd65536 - $signed({1'b0, ao_t});
    assign tot_w   = 20'(r_acc >>> 16);

    // weight and similarity for the current product of the total
    always_comb begin
        unique case (r_mcnt)
            2'd0: begin
                wsel = i_weights.orient;
                ssel = $signed({1'b0, r_s1});
            end
            2'd1: begin
                wsel = i_weights.freq;
                ssel = $signed({1'b0, r_s2});
            end
            2'd2: begin
                wsel = i_weights.avg_freq;
                ssel = $signed({1'b0, r_s3});
            end
            2'd3: begin
                wsel = i_weights.avg_orient;
                ssel = r_s4;
            end
            default: begin
                wsel = '0;
                ssel = '0;
            end
        endcase
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_e         = r_e;
        n_sq        = r_sq;
        n_root_v    = r_root_v;
        n_root_r    = r_root_r;
        n_k         = r_k;
        n_div_run   = r_div_run;
        n_s1        = r_s1;
        n_s2        = r_s2;
        n_s3        = r_s3;
        n_s4        = r_s4;
        n_fault     = r_fault;
        n_mcnt      = r_mcnt;
        n_acc       = r_acc;
        n_out_valid = r_out_valid;
        load_out    = 1'b0;
        o_pop       = 1'b0;
        bm_a        = '0;
        bm_b        = '0;
        div_start   = 1'b0;
        div_num     = '0;
        div_den     = '0;
        unique case (r_state)
            B_IDLE: begin
                if (!i_q_empty) begin
                    o_pop   = 1'b1;
                    n_e     = i_head;
                    n_fault = '0;
                    n_state = B_SQC;
                end
            end
            B_SQC: begin
                bm_a    = 25'(r_e.sum_cos);
                bm_b    = 25'(r_e.sum_cos);
                n_sq    = bm_p[45:0];
                n_state = B_SQS;
            end
            B_SQS: begin
                bm_a     = 25'(r_e.sum_sin);
                bm_b     = 25'(r_e.sum_sin);
                n_root_v = {sq_tot, 16'b0};
                n_root_r = '0;
                n_k      = 5'd30;
                n_state  = B_ROOT;
            end
            B_ROOT: begin
                if (r_root_v >= root_t) begin
                    n_root_v = r_root_v - root_t;
                    n_root_r = (r_root_r >> 1) + root_b;
                end else begin
                    n_root_r = r_root_r >> 1;
                end
                n_k = r_k - 5'd1;
                if (r_k == 5'd0) begin
                    n_state = B_DIV1;
                end
            end
            B_DIV1: begin
                if (!r_div_run) begin
                    if (r_e.sum_weight == '0) begin
                        n_fault[FAULT_WEIGHT] = 1'b1;
                        n_s1    = '0;
                        n_state = B_DIV2;
                    end else begin
                        div_start = 1'b1;
                        div_num   = {1'b0, r_root_r[30:0], 8'b0};
                        div_den   = {1'b0, r_e.sum_weight};
                        n_div_run = 1'b1;
                    end
                end else if (div_done) begin
                    n_s1      = (div_quot > DIV_NUM_W'(ONE_Q16)) ? ONE_Q16 : div_quot[16:0];
                    n_div_run = 1'b0;
                    n_state   = B_DIV2;
                end
            end
            B_DIV2: begin
                if (!r_div_run) begin
                    if (r_e.sum_total == '0) begin
                        n_fault[FAULT_TOTAL] = 1'b1;
                        n_s2    = '0;
                        n_state = B_DIV3;
                    end else begin
                        div_start = 1'b1;
                        div_num   = {2'b0, r_e.sum_absdiff, 16'b0};
                        div_den   = r_e.sum_total;
                        n_div_run = 1'b1;
                    end
                end else if (div_done) begin
                    n_s2      = (div_quot > DIV_NUM_W'(ONE_Q16)) ? '0
                              : (ONE_Q16 - div_quot[16:0]);
                    n_div_run = 1'b0;
                    n_state   = B_DIV3;
                end
            end
            B_DIV3: begin
                if (!r_div_run) begin
                    if (avg_mx == '0) begin
                        n_fault[FAULT_AVG] = 1'b1;
                        n_s3    = '0;
                        n_state = B_S4;
                    end else begin
                        div_start = 1'b1;
                        div_num   = {8'b0, avg_ad, 16'b0};
                        div_den   = {7'b0, avg_mx};
                        n_div_run = 1'b1;
                    end
                end else if (div_done) begin
                    n_s3      = ONE_Q16 - div_quot[16:0];
                    n_div_run = 1'b0;
                    n_state   = B_S4;
                end
            end
            B_S4: begin
                bm_a    = $signed({8'b0, ao_abs});
                bm_b    = $signed(EIGHT_OVER_PI);
                n_s4    = (s4_w < -19'sd65536) ? -18'sd65536 : s4_w[17:0];
                n_mcnt  = 2'd0;
                n_acc   = '0;
                n_state = B_MUL;
            end
            B_MUL: begin
                bm_a   = $signed({9'b0, wsel});
                bm_b   = 25'(ssel);
                n_acc  = r_acc + bm_p[35:0];
                n_mcnt = r_mcnt + 2'd1;
                if (r_mcnt == 2'd3) begin
                    n_state = B_FIN;
                end
            end
            B_FIN: begin
                load_out    = 1'b1;
                n_out_valid = 1'b1;
                n_state     = B_OUT;
            end
            B_OUT: begin
                if (!i_stall) begin
                    n_out_valid = 1'b0;
                    n_state     = B_IDLE;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_div_run   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_div_run   <= n_div_run;
            r_out_valid <= n_out_valid;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_e      <= n_e;
        r_sq     <= n_sq;
        r_root_v <= n_root_v;
        r_root_r <= n_root_r;
        r_k      <= n_k;
        r_s1     <= n_s1;
        r_s2     <= n_s2;
        r_s3     <= n_s3;
        r_s4     <= n_s4;
        r_fault  <= n_fault;
        r_mcnt   <= n_mcnt;
        r_acc    <= n_acc;
    end

    // result register, total rounded down and saturated
    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_o_s1    <= r_s1;
            r_o_s2    <= r_s2;
            r_o_s3    <= r_s3;
            r_o_s4    <= r_s4;
            r_o_ident <= r_e.cand_ident;
            r_o_fault <= r_fault;
            priority if (tot_w > 20'sd65536) begin
                r_o_tot <= 18'sd65536;
            end else if (tot_w < -20'sd65536) begin
                r_o_tot <= -18'sd65536;
            end else begin
                r_o_tot <= tot_w[17:0];
            end
        end
    end

    assign o_valid          = r_out_valid;
    assign o_orient_sim     = r_o_s1;
    assign o_freq_sim       = r_o_s2;
    assign o_avg_freq_sim   = r_o_s3;
    assign o_avg_orient_sim = r_o_s4;
    assign o_total_score    = r_o_tot;
    assign o_result_ident   = r_o_ident;
    assign o_div_fault      = r_o_fault;

endmodule

// ===== hw/rtl/fss_checker.sv =====
// fss_checker: port-level assertions on the similarity block, bound to the top level
// depends on fss_pkg for fault bit positions

module fss_checker
    import fss_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_valid,
    input logic               i_stall,
    input logic [16:0]        o_orient_sim,
    input logic [16:0]        o_avg_freq_sim,
    input logic signed [17:0] o_total_score,
    input logic [2:0]         o_div_fault
);

    // no result straight after reset
    a_reset_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result shown after reset");

    // a stalled result holds its score
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_total_score))
        else $error("stalled result changed");

    // total score stays inside its saturation range
    a_total_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_total_score <= 18'sd65536) && (o_total_score >= -18'sd65536))
        else $error("total score out of range");

    // zero weight sum forces the orientation term to zero
    a_weight_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_div_fault[FAULT_WEIGHT] |-> o_orient_sim == 17'd0)
        else $error("orientation similarity set despite zero weight sum");

    // zero average maximum forces the average frequency term to zero
    a_avg_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_div_fault[FAULT_AVG] |-> o_avg_freq_sim == 17'd0)
        else $error("average frequency similarity set despite zero maximum");

endmodule

bind fingerprint_similarity_score fss_checker u_fss_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_orient_sim   (o_orient_sim),
    .o_avg_freq_sim (o_avg_freq_sim),
    .o_total_score  (o_total_score),
    .o_div_fault    (o_div_fault)
);

// ===== dv/fingerprint_similarity_score_chk.sv =====
// fingerprint_similarity_score_chk: watches the cell, result and weight channels,
// predicts each comparison result and compares it field by field
// depends on fss_pkg for the register indexes and reset weights

module fingerprint_similarity_score_chk
    import fss_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_stall_in,
    input  logic [15:0]        i_query_orient,
    input  logic [15:0]        i_query_coher,
    input  logic [15:0]        i_query_freq,
    input  logic [15:0]        i_cand_orient,
    input  logic [15:0]        i_cand_coher,
    input  logic [15:0]        i_cand_freq,
    input  logic [15:0]        i_query_avg_freq,
    input  logic [15:0]        i_cand_avg_freq,
    input  logic signed [15:0] i_query_avg_orient,
    input  logic signed [15:0] i_cand_avg_orient,
    input  logic [15:0]        i_cand_ident,
    input  logic               i_last_cell,
    input  logic               i_res_valid,
    input  logic               i_res_stall,
    input  logic [16:0]        i_orient_sim,
    input  logic [16:0]        i_freq_sim,
    input  logic [16:0]        i_avg_freq_sim,
    input  logic signed [17:0] i_avg_orient_sim,
    input  logic signed [17:0] i_total_score,
    input  logic [15:0]        i_result_ident,
    input  logic [2:0]         i_div_fault,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic [7:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    output int                 o_fail_count,
    output int                 o_pending
);

    typedef struct packed {
        logic [16:0] orient_sim;
        logic [16:0] freq_sim;
        logic [16:0] avg_freq_sim;
        logic [17:0] avg_orient_sim;
        logic [17:0] total_score;
        logic [15:0] ident;
        logic [2:0]  fault;
    } t_score;

    t_score score_q[$];

    // own copy of the weights and running sums
    longint w_orient, w_freq, w_avg_freq, w_avg_orient;
    longint acc_cos, acc_sin, acc_weight, acc_absdiff, acc_total;

    function automatic longint sine_poly(longint u);
        longint u2, p;
        u2 = (u * u) >>> 16;
        p = 11;
        p = 307 - ((p * u2) >>> 16);
        p = 5223 - ((p * u2) >>> 16);
        p = 42334 - ((p * u2) >>> 16);
        p = 102944 - ((p * u2) >>> 16);
        p = (p * u) >>> 16;
        return (p > 65536) ? 65536 : p;
    endfunction

    function automatic longint int_root(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return longint'(r);
    endfunction

    function automatic longint scale_trig(longint w, longint trig);
        longint mag;
        mag = (trig < 0) ? -trig : trig;
        mag = (w * mag) >>> 16;
        return (trig < 0) ? -mag : mag;
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return (v > hi) ? hi : ((v < lo) ? lo : v);
    endfunction

    // accumulate one cell pair; returns 1 with the score on a last cell
    function automatic bit score_cell(output t_score sc);
        longint w, d, rem, quad, u, su, sco, sn, cs, qf, cf;
        longint s1, s2, s3, s4, qa, ca, mx, a, t, acc, tot, c, s;
        logic [2:0] fault;
        w = (longint'(i_query_coher) * longint'(i_cand_coher)) >>> 16;
        d = 2 * (longint'(i_query_orient) - longint'(i_cand_orient)) + 184320;
        rem = d % 92160;
        quad = rem / 23040;
        u = ((rem % 23040) * 65536) / 23040;
        su = sine_poly(u);
        sco = sine_poly(65536 - u);
        case (quad)
            0: begin sn = su; cs = sco; end
            1: begin sn = sco; cs = -su; end
            2: begin sn = -su; cs = -sco; end
            default: begin sn = -sco; cs = su; end
        endcase
        qf = i_query_freq;
        cf = i_cand_freq;
        acc_cos = clip(acc_cos + scale_trig(w, cs), -4194304, 4194303);
        acc_sin = clip(acc_sin + scale_trig(w, sn), -4194304, 4194303);
        acc_weight = clip(acc_weight + w, 0, 4194303);
        acc_absdiff = clip(acc_absdiff + ((qf > cf) ? qf - cf : cf - qf), 0, 4194303);
        acc_total = clip(acc_total + qf + cf, 0, 8388607);
        sc = '0;
        if (!i_last_cell) return 1'b0;

        fault = 3'b000;
        s1 = 0; s2 = 0; s3 = 0;
        if (acc_weight == 0) fault[FAULT_WEIGHT] = 1'b1;
        else begin
            c = acc_cos;
            s = acc_sin;
            s1 = (int_root(longint'(c * c + s * s) << 16) * 256) / acc_weight;
            if (s1 > 65536) s1 = 65536;
        end
        if (acc_total == 0) fault[FAULT_TOTAL] = 1'b1;
        else begin
            t = (acc_absdiff * 65536) / acc_total;
            s2 = (t > 65536) ? 0 : 65536 - t;
        end
        qa = i_query_avg_freq;
        ca = i_cand_avg_freq;
        mx = (qa > ca) ? qa : ca;
        if (mx == 0) fault[FAULT_AVG] = 1'b1;
        else s3 = 65536 - ((((qa > ca) ? qa - ca : ca - qa) * 65536) / mx);
        a = longint'(i_query_avg_orient) - longint'(i_cand_avg_orient);
        if (a < 0) a = -a;
        s4 = 65536 - ((a * 166886) >>> 16);
        if (s4 < -65536) s4 = -65536;
        acc = w_orient * s1 + w_freq * s2 + w_avg_freq * s3 + w_avg_orient * s4;
        tot = clip(acc >>> 16, -65536, 65536);

        sc.orient_sim     = s1[16:0];
        sc.freq_sim       = s2[16:0];
        sc.avg_freq_sim   = s3[16:0];
        sc.avg_orient_sim = s4[17:0];
        sc.total_score    = tot[17:0];
        sc.ident          = i_cand_ident;
        sc.fault          = fault;
        acc_cos = 0; acc_sin = 0; acc_weight = 0; acc_absdiff = 0; acc_total = 0;
        return 1'b1;
    endfunction

    // cell, weight and result transactions
    always @(posedge i_clk) begin
        t_score sc, want;
        if (!i_rst_n) begin
            w_orient <= RST_WEIGHT_ORIENT;
            w_freq <= RST_WEIGHT_FREQ;
            w_avg_freq <= RST_WEIGHT_AVG_FREQ;
            w_avg_orient <= RST_WEIGHT_AVG_ORIENT;
            acc_cos = 0; acc_sin = 0; acc_weight = 0; acc_absdiff = 0; acc_total = 0;
            score_q.delete();
            o_fail_count <= 0;
            o_pending <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_WEIGHT_ORIENT:     w_orient <= i_cfg_data;
                    REG_WEIGHT_FREQ:       w_freq <= i_cfg_data;
                    REG_WEIGHT_AVG_FREQ:   w_avg_freq <= i_cfg_data;
                    REG_WEIGHT_AVG_ORIENT: w_avg_orient <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_valid && !i_stall_in) begin
                if (score_cell(sc)) score_q = {score_q, sc};
            end
            if (i_res_valid && !i_res_stall) begin
                if (score_q.size() == 0) begin
                    $display("%0t: unexpected result, actual %h", $time,
                             {i_orient_sim, i_freq_sim, i_avg_freq_sim, i_avg_orient_sim,
                              i_total_score, i_result_ident, i_div_fault});
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = score_q.pop_front();
                    if (want.orient_sim !== i_orient_sim ||
                        want.freq_sim !== i_freq_sim ||
                        want.avg_freq_sim !== i_avg_freq_sim ||
                        want.avg_orient_sim !== i_avg_orient_sim ||
                        want.total_score !== i_total_score ||
                        want.ident !== i_result_ident ||
                        want.fault !== i_div_fault) begin
                        $display("%0t: score mismatch expected os=%0d fs=%0d afs=%0d aos=%0d",
                                 $time, want.orient_sim, want.freq_sim, want.avg_freq_sim,
                                 $signed(want.avg_orient_sim));
                        $display("    tot=%0d id=%0d flt=%0d, actual os=%0d fs=%0d afs=%0d",
                                 $signed(want.total_score), want.ident, want.fault,
                                 i_orient_sim, i_freq_sim, i_avg_freq_sim);
                        $display("    aos=%0d tot=%0d id=%0d flt=%0d", i_avg_orient_sim,
                                 i_total_score, i_result_ident, i_div_fault);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            o_pending <= score_q.size();
        end
    end

endmodule

// ===== dv/fingerprint_similarity_score_tb.sv =====
// fingerprint_similarity_score_tb: clock, reset, cell and weight stimulus and the verdict
// depends on fss_pkg, fingerprint_similarity_score and fingerprint_similarity_score_chk

module fingerprint_similarity_score_tb;
    import fss_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int SETTLE = 400;

    logic               i_clk, i_rst_n;
    logic               i_valid, o_stall, o_valid, i_stall;
    logic [15:0]        i_query_orient, i_query_coher, i_query_freq;
    logic [15:0]        i_cand_orient, i_cand_coher, i_cand_freq;
    logic [15:0]        i_query_avg_freq, i_cand_avg_freq;
    logic signed [15:0] i_query_avg_orient, i_cand_avg_orient;
    logic [15:0]        i_cand_ident;
    logic               i_last_cell;
    logic [16:0]        o_orient_sim, o_freq_sim, o_avg_freq_sim;
    logic signed [17:0] o_avg_orient_sim, o_total_score;
    logic [15:0]        o_result_ident;
    logic [2:0]         o_div_fault;
    logic               i_cfg_valid, o_cfg_ready;
    logic [7:0]         i_cfg_index;
    logic [15:0]        i_cfg_data;
    int                 fail_count, pending, cycles, stall_left;
    bit                 calm;

    fingerprint_similarity_score u_dut (.*);

    fingerprint_similarity_score_chk u_chk (
        .i_clk, .i_rst_n, .i_valid, .i_stall_in(o_stall),
        .i_query_orient, .i_query_coher, .i_query_freq,
        .i_cand_orient, .i_cand_coher, .i_cand_freq,
        .i_query_avg_freq, .i_cand_avg_freq, .i_query_avg_orient, .i_cand_avg_orient,
        .i_cand_ident, .i_last_cell,
        .i_res_valid(o_valid), .i_res_stall(i_stall),
        .i_orient_sim(o_orient_sim), .i_freq_sim(o_freq_sim),
        .i_avg_freq_sim(o_avg_freq_sim), .i_avg_orient_sim(o_avg_orient_sim),
        .i_total_score(o_total_score), .i_result_ident(o_result_ident),
        .i_div_fault(o_div_fault),
        .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_index, .i_cfg_data,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // watchdog
    initial cycles = 0;
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic int draw_gap();
        return calm ? 0 : $urandom_range(0, 17);
    endfunction

    // result receiver: stall for a drawn number of cycles after each transaction
    always @(posedge i_clk) begin
        int n;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            stall_left <= 0;
        end else if (i_stall) begin
            if (stall_left <= 1) i_stall <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (o_valid) begin
            n = draw_gap();
            if (n > 0) begin
                i_stall <= 1'b1;
                stall_left <= n;
            end
        end
    end

    task automatic send_cell(input logic [15:0] qo, qc, qf, co, cc, cf, qa, ca,
                             input logic [15:0] qao, cao, ident, input logic last);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_query_orient <= qo; i_query_coher <= qc; i_query_freq <= qf;
        i_cand_orient <= co; i_cand_coher <= cc; i_cand_freq <= cf;
        i_query_avg_freq <= qa; i_cand_avg_freq <= ca;
        i_query_avg_orient <= qao; i_cand_avg_orient <= cao;
        i_cand_ident <= ident; i_last_cell <= last;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic write_weight(input logic [7:0] idx, input logic [15:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    function automatic logic [15:0] rand_orient();
        return ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 46080));
    endfunction

    function automatic logic [15:0] rand_avg_orient();
        int v;
        v = $urandom_range(0, 51472) - 25736;
        return ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'(v);
    endfunction

    // one comparison of random cells, occasionally long and at full scale
    task automatic send_comparison(output int sent);
        int n;
        bit full;
        full = ($urandom_range(0, 19) == 0);
        n = full ? $urandom_range(37, 80) : $urandom_range(1, 6);
        for (int k = 0; k < n; k++) begin
            send_cell(full ? 16'd0 : rand_orient(), full ? 16'hFFFF : 16'($urandom),
                      full ? 16'hFFFF : 16'($urandom), rand_orient(),
                      full ? 16'hFFFF : 16'($urandom),
                      ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom),
                      16'($urandom), 16'($urandom), rand_avg_orient(), rand_avg_orient(),
                      16'($urandom), k == n - 1);
        end
        sent = n;
    endtask

    initial begin
        int sent, total;
        logic [15:0] wset [4];
        calm = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        {i_query_orient, i_query_coher, i_query_freq, i_cand_orient, i_cand_coher,
         i_cand_freq, i_query_avg_freq, i_cand_avg_freq, i_query_avg_orient,
         i_cand_avg_orient, i_cand_ident} = '0;
        i_last_cell = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: all divisors zero, extremes of orientation, frequency and ids
        send_cell(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1);
        send_cell(0, 16'hFFFF, 16'hFFFF, 46080, 16'hFFFF, 0, 16'hFFFF, 0,
                  16'sd25736, -16'sd25736, 16'hFFFF, 1);
        send_cell(16'hFFFF, 16'hFFFF, 0, 0, 16'hFFFF, 16'hFFFF, 0, 16'hFFFF,
                  16'h7FFF, 16'h8000, 16'h1234, 1);
        send_cell(11520, 16'hFFFF, 100, 0, 16'hFFFF, 100, 500, 500, 0, 0, 16'h0001, 0);
        send_cell(23040, 16'h8000, 200, 0, 16'h8000, 50, 500, 500, 0, 0, 16'h0002, 0);
        send_cell(34560, 16'h4000, 300, 0, 16'h4000, 900, 500, 500, 0, 0, 16'h0003, 1);
        send_cell(0, 1, 1, 16'hFFFF, 1, 1, 1, 16'hFFFF, 16'h8000, 16'h7FFF, 16'hAAAA, 1);
        send_cell(46080, 16'hFFFF, 16'hFFFF, 46080, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                  16'hFFFF, -16'sd25736, 16'sd25736, 16'h5555, 1);
        // weight sum zero but frequency present
        send_cell(100, 0, 500, 200, 16'hFFFF, 700, 0, 300, 16'sd100, -16'sd100, 16'h00FF, 1);
        drain();

        total = 0;
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: wset = '{16'h0000, 16'h0000, 16'h0000, 16'h0000};
                1: wset = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
                2: wset = '{16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)};
                3: wset = '{16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF};
                default: wset = '{RST_WEIGHT_ORIENT, RST_WEIGHT_FREQ,
                                  RST_WEIGHT_AVG_FREQ, RST_WEIGHT_AVG_ORIENT};
            endcase
            write_weight(REG_WEIGHT_ORIENT, wset[0]);
            write_weight(REG_WEIGHT_FREQ, wset[1]);
            write_weight(REG_WEIGHT_AVG_FREQ, wset[2]);
            write_weight(REG_WEIGHT_AVG_ORIENT, wset[3]);
            // an index beyond the register file is ignored
            write_weight(8'd4 + 8'($urandom_range(0, 251)), 16'($urandom));
            for (int c = 0; c < 300; c += sent) begin
                calm = ($urandom_range(0, 5) == 0);
                send_comparison(sent);
            end
            calm = 1'b0;
            drain();
        end

        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
